// ===== src/rtpst_pkg.sv =====
package rtpst_pkg;

  localparam int unsigned ARRIVAL_WIDTH_DEF = 48;
  localparam int unsigned RATE_W            = 24;
  localparam int unsigned SEQ_W             = 16;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // sequence, timestamp and source ahead of the arrival time in the input word
  localparam int unsigned IN_FIXED_W = SEQ_W + 2 * WORD_W;

  // packet class decided at the front
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_COUNTED,
    KIND_FOREIGN
  } pkt_kind_t;

  typedef struct packed {
    pkt_kind_t          kind;
    logic [SEQ_W-1:0]   seq;
    logic [WORD_W-1:0]  ts;
  } item_hdr_t;

  // field order gives extended highest sequence in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0] jitter;
    logic [WORD_W-1:0] lost;
    logic [WORD_W-1:0] received;
    logic [WORD_W-1:0] expected;
    logic [WORD_W-1:0] highest;
  } stats_t;

  localparam int unsigned OUT_TDATA_W = $bits(stats_t);
  localparam int unsigned HDR_W       = $bits(item_hdr_t);

endpackage

// ===== src/rtpst_front.sv =====
module rtpst_front #(
  parameter  int unsigned ARRIVAL_WIDTH = rtpst_pkg::ARRIVAL_WIDTH_DEF,
  localparam int unsigned IN_TDATA_W    = ((rtpst_pkg::IN_FIXED_W + ARRIVAL_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_W-1:0]      in_tdata,
  input  logic                       q_full,
  output logic                       q_push,
  output rtpst_pkg::item_hdr_t       q_hdr,
  output logic [ARRIVAL_WIDTH-1:0]   q_arrival
);
  import rtpst_pkg::*;

  logic [SEQ_W-1:0]  seq;
  logic [WORD_W-1:0] ts;
  logic [WORD_W-1:0] src;
  logic              awaiting_r;
  logic [WORD_W-1:0] tracked_r;
  pkt_kind_t         kind;

  assign seq       = in_tdata[SEQ_W-1:0];
  assign ts        = in_tdata[SEQ_W +: WORD_W];
  assign src       = in_tdata[SEQ_W + WORD_W +: WORD_W];
  assign q_arrival = in_tdata[IN_FIXED_W +: ARRIVAL_WIDTH];

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    if (awaiting_r) begin
      kind = KIND_FIRST;
    end else if (src == tracked_r) begin
      kind = KIND_COUNTED;
    end else begin
      kind = KIND_FOREIGN;
    end
  end

  assign q_hdr = '{kind: kind, seq: seq, ts: ts};

  // first word latches the source for good
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      tracked_r  <= '0;
    end else if (q_push && awaiting_r) begin
      awaiting_r <= 1'b0;
      tracked_r  <= src;
    end
  end

  a_latch_once: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_r |=> !awaiting_r)
    else $error("source latch reopened");

endmodule

// ===== src/rtpst_queue.sv =====
module rtpst_queue #(
  parameter int unsigned WIDTH = rtpst_pkg::HDR_W + rtpst_pkg::ARRIVAL_WIDTH_DEF,
  parameter int unsigned DEPTH = rtpst_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue overfilled");

endmodule

// ===== src/rtpst_back.sv =====
module rtpst_back #(
  parameter int unsigned ARRIVAL_WIDTH = rtpst_pkg::ARRIVAL_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rtpst_pkg::RATE_W-1:0]       cfg_wr_data,
  input  logic                               q_valid,
  input  rtpst_pkg::item_hdr_t               q_hdr,
  input  logic [ARRIVAL_WIDTH-1:0]           q_arrival,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rtpst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [rtpst_pkg::STATUS_W-1:0]     out_tuser
);
  import rtpst_pkg::*;

  localparam logic [STATUS_W-1:0] STATUS_FIRST   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_COUNTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FOREIGN = 2'd2;

  localparam logic [WORD_W-1:0] ROLL_MASK = 32'hFFFF_0000;
  localparam logic [SEQ_W-1:0]  HALF_SPAN = 16'h8000;
  localparam logic [WORD_W-1:0] WRAP_STEP = 32'h0001_0000;

  // ms to media units: divide by 1000 as a shift by 3 then a divide by 125
  localparam int unsigned DIV_SHIFT = 3;
  localparam logic [7:0]  DIVISOR   = 8'd125;

  localparam int unsigned NCH      = (ARRIVAL_WIDTH + WORD_W - 1) / WORD_W;
  localparam int unsigned CHUNK_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned ARR_PAD  = NCH * WORD_W;
  localparam int unsigned PP_W     = WORD_W + RATE_W;
  localparam int unsigned PROD_W   = ARRIVAL_WIDTH + RATE_W;
  localparam int unsigned QUOT_W   = PROD_W - DIV_SHIFT;
  localparam int unsigned NBYTES   = (QUOT_W + 7) / 8;
  localparam int unsigned DV_W     = NBYTES * 8;
  localparam int unsigned DCNT_W   = $clog2(NBYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_EXP,
    S_LOSS,
    S_MUL,
    S_ACC,
    S_DIV,
    S_TRANSIT,
    S_JITTER,
    S_OUT
  } state_t;

  // one byte of long division by 125, remainder kept below the divisor
  function automatic logic [14:0] div_byte(input logic [6:0] rem, input logic [7:0] din);
    logic [7:0] r;
    logic [7:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[6:0], din[i]};
      if (r >= DIVISOR) begin
        r    = r - DIVISOR;
        q[i] = 1'b1;
      end
    end
    return {q, r[6:0]};
  endfunction

  state_t               state_r;
  logic [RATE_W-1:0]    rate_r;
  item_hdr_t            hdr_r;
  logic [ARR_PAD-1:0]   arr_r;
  logic [STATUS_W-1:0]  status_r;

  logic [WORD_W-1:0]    highest_r;
  logic [WORD_W-1:0]    base_r;
  logic [WORD_W-1:0]    received_r;
  logic [WORD_W-1:0]    expected_r;
  logic [WORD_W-1:0]    lost_r;
  logic [WORD_W-1:0]    prev_transit_r;
  logic [WORD_W-1:0]    jitter_r;

  logic [CHUNK_W-1:0]   chunk_r;
  logic [PP_W-1:0]      prod_r;
  logic [PROD_W-1:0]    acc_r;
  logic [PROD_W-1:0]    acc_nxt;
  logic [DV_W-1:0]      dv_r;
  logic [6:0]           rem_r;
  logic [DCNT_W-1:0]    div_cnt_r;
  logic [WORD_W-1:0]    delta_r;
  logic                 jit_run_r;

  logic                 out_valid_r;
  stats_t               out_data_r;
  logic [STATUS_W-1:0]  out_user_r;

  logic [SEQ_W-1:0]     seq_low;
  logic [WORD_W-1:0]    cand;
  logic [14:0]          div_step;
  logic [WORD_W-1:0]    transit;
  logic [WORD_W-1:0]    magnitude;
  logic signed [33:0]   jit_t;
  logic signed [33:0]   jit_adj;
  logic                 out_load;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // sequence extension with forward wrap
  always_comb begin
    seq_low = highest_r[SEQ_W-1:0];
    cand    = (highest_r & ROLL_MASK) | WORD_W'(hdr_r.seq);
    if (hdr_r.seq < seq_low && (seq_low - hdr_r.seq) > HALF_SPAN) begin
      cand = cand + WRAP_STEP;
    end
  end

  assign acc_nxt  = acc_r + (PROD_W'(prod_r) << (WORD_W * chunk_r));
  assign div_step = div_byte(rem_r, dv_r[DV_W-1 -: 8]);
  assign transit  = dv_r[WORD_W-1:0] - hdr_r.ts;

  // signed jitter step: (|D| - J + 8) >> 4 with floor rounding
  always_comb begin
    magnitude = delta_r[WORD_W-1] ? (~delta_r + 1'b1) : delta_r;
    jit_t     = $signed({2'b00, magnitude}) - $signed({2'b00, jitter_r}) + 34'sd8;
    jit_adj   = jit_t >>> 4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      rate_r         <= '0;
      highest_r      <= '0;
      base_r         <= '0;
      received_r     <= '0;
      expected_r     <= '0;
      lost_r         <= '0;
      prev_transit_r <= '0;
      jitter_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end

      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            hdr_r   <= q_hdr;
            arr_r   <= ARR_PAD'(q_arrival);
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (hdr_r.kind)
            KIND_FIRST: begin
              highest_r  <= WORD_W'(hdr_r.seq);
              base_r     <= WORD_W'(hdr_r.seq);
              received_r <= WORD_W'(1);
              expected_r <= WORD_W'(1);
              status_r   <= STATUS_FIRST;
              state_r    <= S_OUT;
            end
            KIND_COUNTED: begin
              received_r <= received_r + 1'b1;
              if (cand > highest_r) begin
                highest_r <= cand;
              end
              status_r <= STATUS_COUNTED;
              state_r  <= S_EXP;
            end
            default: begin
              status_r <= STATUS_FOREIGN;
              state_r  <= S_OUT;
            end
          endcase
        end
        S_EXP: begin
          expected_r <= highest_r - base_r + 1'b1;
          state_r    <= S_LOSS;
        end
        S_LOSS: begin
          lost_r <= (expected_r > received_r) ? expected_r - received_r : '0;
          if (rate_r != '0) begin
            chunk_r <= '0;
            acc_r   <= '0;
            state_r <= S_MUL;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_MUL: begin
          prod_r  <= PP_W'(arr_r[chunk_r * WORD_W +: WORD_W]) * PP_W'(rate_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_nxt;
          if (chunk_r == CHUNK_W'(NCH - 1)) begin
            dv_r      <= DV_W'(acc_nxt[PROD_W-1:DIV_SHIFT]);
            rem_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end else begin
            chunk_r <= chunk_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DIV: begin
          dv_r      <= {dv_r[DV_W-9:0], div_step[14:7]};
          rem_r     <= div_step[6:0];
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DCNT_W'(NBYTES - 1)) begin
            state_r <= S_TRANSIT;
          end
        end
        S_TRANSIT: begin
          delta_r        <= transit - prev_transit_r;
          jit_run_r      <= (prev_transit_r != '0);
          prev_transit_r <= transit;
          state_r        <= S_JITTER;
        end
        S_JITTER: begin
          if (jit_run_r) begin
            jitter_r <= jitter_r + jit_adj[WORD_W-1:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{jitter:   jitter_r,
                             lost:     lost_r,
                             received: received_r,
                             expected: expected_r,
                             highest:  highest_r};
            out_user_r  <= status_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_lost_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && lost_r != '0) |-> (lost_r == expected_r - received_r))
    else $error("lost count out of step with expected and received");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < DCNT_W'(NBYTES)))
    else $error("divide loop overran");

endmodule

// ===== src/rtp_receive_statistics.sv =====
// channel  | direction | ports                 | contents (lowest bit up)
// ---------+-----------+-----------------------+---------------------------------------------
// in       | slave     | in_tvalid/tready/tdata | sequence, timestamp, source id, arrival ms
// out      | master    | out_tvalid/tready/tdata/tuser | stats in tdata, packet status in tuser
// cfg      | write     | cfg_wr_en/cfg_wr_data  | media clock rate in Hz
//
// a first-packet or foreign-source word goes through the idle, execute and output steps;
// a counted one also the expected and loss steps, and with a nonzero rate (jitter on) the
// 32 x 24 multiply loop, the byte-a-cycle divide by 125 and the transit and jitter steps
// a two-entry queue between front and back keeps accepting words while one is worked on
// and while a finished result waits; out_tready low only holds the back at its output step
// rst_n is synchronous, active low, and clears the source latch, all statistics and the rate
module rtp_receive_statistics #(
  parameter  int unsigned ARRIVAL_WIDTH = rtpst_pkg::ARRIVAL_WIDTH_DEF,
  localparam int unsigned IN_TDATA_W    = ((rtpst_pkg::IN_FIXED_W + ARRIVAL_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input word
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // sequence_number, media_timestamp, source_id, arrival_time_ms, zero fill
  input  logic [IN_TDATA_W-1:0]              in_tdata,
  // result word
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // extended_highest_seq, expected_count, received_count, packets_lost, jitter_estimate
  output logic [rtpst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // packet_status
  output logic [rtpst_pkg::STATUS_W-1:0]     out_tuser,
  // media clock rate register
  input  logic                               cfg_wr_en,
  input  logic [rtpst_pkg::RATE_W-1:0]       cfg_wr_data
);
  import rtpst_pkg::*;

  localparam int unsigned Q_W = HDR_W + ARRIVAL_WIDTH;

  // front side of the queue
  logic                       push;
  logic                       q_full;
  item_hdr_t                  push_hdr;
  logic [ARRIVAL_WIDTH-1:0]   push_arrival;

  // back side of the queue
  logic                       pop;
  logic                       q_valid;
  logic [Q_W-1:0]             pop_data;
  item_hdr_t                  pop_hdr;
  logic [ARRIVAL_WIDTH-1:0]   pop_arrival;

  assign pop_hdr     = pop_data[HDR_W-1:0];
  assign pop_arrival = pop_data[HDR_W +: ARRIVAL_WIDTH];

  // classifies each word and latches the source from the first one
  rtpst_front #(
    .ARRIVAL_WIDTH (ARRIVAL_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (push),
    .q_hdr     (push_hdr),
    .q_arrival (push_arrival)
  );

  rtpst_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_arrival, push_hdr}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  // sequence tracking, counts, arrival conversion and jitter, with the output register
  rtpst_back #(
    .ARRIVAL_WIDTH (ARRIVAL_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_hdr       (pop_hdr),
    .q_arrival   (pop_arrival),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

typedef struct {
  rtpst_pkg::pkt_kind_t kind;
  rtpst_pkg::stats_t    stats;
} rtp_report_t;

// receiver-side statistics predictor plus the queue of reports still owed by the block
class rtp_stats_tracker;
  logic [23:0]   media_rate;
  bit            awaiting_first;
  logic [31:0]   tracked_source;
  logic [31:0]   highest_ext;
  logic [31:0]   seq_base;
  logic [31:0]   rx_total;
  logic [31:0]   exp_total;
  logic [31:0]   lost_total;
  logic [31:0]   prev_transit;
  logic [31:0]   jitter;
  rtp_report_t   pending_reports[$];
  int            failures;
  int            n_first;
  int            n_counted;
  int            n_foreign;

  function new();
    media_rate     = '0;
    awaiting_first = 1'b1;
    tracked_source = '0;
    highest_ext    = '0;
    seq_base       = '0;
    rx_total       = '0;
    exp_total      = '0;
    lost_total     = '0;
    prev_transit   = '0;
    jitter         = '0;
    failures       = 0;
    n_first        = 0;
    n_counted      = 0;
    n_foreign      = 0;
  endfunction

  function void set_rate(logic [23:0] rate);
    media_rate = rate;
  endfunction

  function void note_packet(logic [15:0] seq, logic [31:0] ts, logic [31:0] src,
                            logic [47:0] ms);
    rtp_report_t        r;
    logic [31:0]        cand;
    logic [31:0]        transit;
    logic [31:0]        diff;
    logic [31:0]        mag;
    logic [71:0]        product;
    logic signed [63:0] step;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      tracked_source = src;
      highest_ext    = {16'h0, seq};
      seq_base       = {16'h0, seq};
      rx_total       = 32'd1;
      exp_total      = 32'd1;
      r.kind         = rtpst_pkg::KIND_FIRST;
      n_first++;
    end else if (src != tracked_source) begin
      r.kind = rtpst_pkg::KIND_FOREIGN;
      n_foreign++;
    end else begin
      r.kind   = rtpst_pkg::KIND_COUNTED;
      rx_total = rx_total + 32'd1;
      cand     = {highest_ext[31:16], seq};
      // sequence fell back by more than half the space: a forward wrap
      if (seq < highest_ext[15:0] &&
          ({16'h0, highest_ext[15:0]} - {16'h0, seq}) > 32'h8000)
        cand = cand + 32'h10000;
      if (cand > highest_ext)
        highest_ext = cand;
      exp_total  = highest_ext - seq_base + 32'd1;
      lost_total = (exp_total > rx_total) ? exp_total - rx_total : 32'd0;
      if (media_rate != 0) begin
        product = ms * media_rate;
        transit = 32'(product / 72'd1000) - ts;
        if (prev_transit != 0) begin
          diff   = transit - prev_transit;
          mag    = diff[31] ? -diff : diff;
          // floor division by 16 with rounding, kept signed
          step   = $signed({32'h0, mag}) - $signed({32'h0, jitter}) + 64'sd8;
          jitter = jitter + 32'(step >>> 4);
        end
        prev_transit = transit;
      end
      n_counted++;
    end
    r.stats.highest  = highest_ext;
    r.stats.expected = exp_total;
    r.stats.received = rx_total;
    r.stats.lost     = lost_total;
    r.stats.jitter   = jitter;
    pending_reports.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function void check_report(logic [1:0] status, rtpst_pkg::stats_t got);
    rtp_report_t r;
    if (pending_reports.size() == 0) begin
      failures++;
      $display("%0t unexpected report: expected none actual status %0d stats %h",
               $time, status, got);
      return;
    end
    r = pending_reports.pop_front();
    compare_field("packet_status", {30'h0, r.kind}, {30'h0, status});
    compare_field("extended_highest_seq", r.stats.highest, got.highest);
    compare_field("expected_count", r.stats.expected, got.expected);
    compare_field("received_count", r.stats.received, got.received);
    compare_field("packets_lost", r.stats.lost, got.lost);
    compare_field("jitter_estimate", r.stats.jitter, got.jitter);
  endfunction
endclass

module tb;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // sequence_number, media_timestamp, source_id, arrival_time_ms
  logic [127:0]      in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  // extended_highest_seq, expected_count, received_count, packets_lost, jitter_estimate
  rtpst_pkg::stats_t out_tdata;
  // packet_status
  logic [1:0]        out_tuser;
  logic              cfg_wr_en;
  logic [23:0]       cfg_wr_data;

  rtp_stats_tracker  tracker;
  logic [31:0]       stream_src;
  logic [47:0]       stream_ms;
  logic [15:0]       stream_seq;
  int                tx_calm;
  int                rx_calm;
  int                rate_writes;
  int                words_sent;

  rtp_receive_statistics u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // called and left at a falling edge
  task automatic send_packet(logic [15:0] seq, logic [31:0] ts, logic [31:0] src,
                             logic [47:0] ms);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap     = 0;
      tx_calm = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 19);
    end
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {ms, src, ts, seq};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.note_packet(seq, ts, src, ms);
    words_sent++;
    @(negedge clk);
  endtask

  // rate changes only once every owed report is back
  task automatic write_rate(logic [23:0] rate);
    in_tvalid = 1'b0;
    while (tracker.pending_reports.size() != 0) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = rate;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.set_rate(rate);
    rate_writes++;
  endtask

  // mostly a plausible packet stream from the latched source, plus foreign and noisy words
  task automatic run_phase(int n_items, logic [23:0] rate);
    int          pick;
    logic [31:0] offset;
    logic [71:0] product;
    logic [31:0] units;
    write_rate(rate);
    stream_ms = {16'($urandom), 32'($urandom)};
    offset    = $urandom;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        logic [31:0] src;
        src = $urandom;
        if (src == stream_src)
          src = ~src;
        send_packet(16'($urandom), $urandom, src, {16'($urandom), 32'($urandom)});
      end else if (pick < 17) begin
        send_packet(16'($urandom), $urandom, stream_src, {16'($urandom), 32'($urandom)});
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 78)
          stream_seq = stream_seq + 16'd1;
        else if (pick < 86)
          stream_seq = stream_seq + 16'($urandom_range(2, 40));
        else if (pick < 91)
          stream_seq = stream_seq - 16'($urandom_range(1, 6));
        else if (pick >= 95)
          stream_seq = 16'($urandom);
        // else a duplicate
        stream_ms = stream_ms + 48'($urandom_range(0, 40));
        if ($urandom_range(0, 49) == 0)
          stream_ms = stream_ms + 48'($urandom_range(0, 1 << 20));
        product = stream_ms * rate;
        units   = 32'(product / 72'd1000);
        send_packet(stream_seq, units - offset + 32'($urandom_range(0, 64)), stream_src,
                    stream_ms);
      end
    end
  endtask

  // result side: random stalls, with calm stretches
  initial begin
    int stall;
    out_tready = 1'b0;
    rx_calm    = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_calm > 0) begin
        stall = 0;
        rx_calm--;
      end else if ($urandom_range(0, 19) == 0) begin
        stall   = 0;
        rx_calm = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      tracker.check_report(out_tuser, out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [23:0] rates[6];
    tracker      = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    tx_calm      = 0;
    rate_writes  = 0;
    words_sent   = 0;
    stream_src   = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: at 1000 Hz the arrival in clock units is just the low 32 bits of ms
    write_rate(24'd1000);
    send_packet(16'hFFF0, 32'd0, stream_src, 48'd100);                 // latches the source
    send_packet(16'hFFF0, 32'd3, stream_src, 48'd101);                 // duplicate
    send_packet(16'hFFF0, 32'd4, stream_src, 48'd102);                 // loss floored at zero
    send_packet(16'h1234, 32'd5, ~stream_src, 48'd200);                // foreign source
    send_packet(16'h0000, 32'hFFFF_FFFF, stream_src ^ 32'h8000_0001, 48'd0);
    send_packet(16'hFFF1, 32'd10, stream_src, 48'd120);
    send_packet(16'hFFF2, 32'd20, stream_src, 48'd135);                // small rise
    send_packet(16'h0003, 32'd30, stream_src, 48'd400);                // forward wrap
    send_packet(16'h0001, 32'd40, stream_src, 48'd405);                // reordered
    send_packet(16'h0004, 32'd5000, stream_src, 48'd405);              // transit falls
    send_packet(16'h0009, 32'd0, stream_src, 48'd1000);                // gap in sequence
    send_packet(16'h000A, 32'h8000_0000, stream_src, 48'd1000);        // half-range swing
    send_packet(16'h000B, 32'd1100, stream_src, 48'd1100);             // zero transit
    send_packet(16'h000C, 32'd7, stream_src, 48'd1200);                // no previous transit
    send_packet(16'hFFFF, 32'hFFFF_FFFF, stream_src, 48'hFFFF_FFFF_FFFF);
    send_packet(16'h0000, 32'h0000_0000, stream_src, 48'h0000_0000_0000);
    send_packet(16'hFFFF, 32'hFFFF_FFFF,
                (stream_src == 32'hFFFF_FFFF) ? 32'h0 : 32'hFFFF_FFFF,
                48'hFFFF_FFFF_FFFF);
    stream_seq = 16'h0001;

    rates[0] = 24'd0;
    rates[1] = 24'hFF_FFFF;
    rates[2] = 24'd8000;
    rates[3] = 24'd90000;
    rates[4] = 24'd1;
    rates[5] = 24'($urandom);
    foreach (rates[k])
      run_phase(172, rates[k]);

    in_tvalid = 1'b0;
    while (tracker.pending_reports.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d packets (%0d latched, %0d counted, %0d foreign)",
             words_sent, tracker.n_first, tracker.n_counted, tracker.n_foreign);
    $display("over %0d clock rate settings, zero and full scale among them", rate_writes);
    if (tracker.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
src/rtpst_pkg.sv
src/rtpst_front.sv
src/rtpst_queue.sv
src/rtpst_back.sv
src/rtp_receive_statistics.sv
tb/tb.sv
